// ----- rtl/stereo_allpass_width_mixer_assert.svh -----
// Assertion macros for the stereo width mixer.
`ifndef STEREO_ALLPASS_WIDTH_MIXER_ASSERT_SVH
`define STEREO_ALLPASS_WIDTH_MIXER_ASSERT_SVH

// Same-cycle implication.
`define SAWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SAWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sawm_pkg.sv -----
package sawm_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 16;
  localparam int CFRAC      = COEF_W - 1;
  localparam int ONSET_W    = 17;
  localparam int ONSET_FRAC = 16;
  localparam int ONSET_ONE  = 1 << ONSET_FRAC;
  localparam int CFG_W      = (COEF_W > ONSET_W) ? COEF_W : ONSET_W;
  localparam int CFG_IDX_W  = 3;
  localparam int MIX_THRESH = (1 << CFRAC) / 10000;

  // shared multiplier operand and accumulator widths
  localparam int MA_W  = SAMPLE_W + 1;
  localparam int MB_W  = (COEF_W + 2 > ONSET_W + 1) ? COEF_W + 2 : ONSET_W + 1;
  localparam int ACC_W = SAMPLE_W + COEF_W + 4;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_L = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_R = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MIX    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SIDE   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = CFG_IDX_W'(4);

  localparam logic signed [COEF_W-1:0] RST_GAIN_L = COEF_W'(11469);
  localparam logic signed [COEF_W-1:0] RST_GAIN_R = COEF_W'(-11469);
  localparam logic [COEF_W-2:0]        RST_MIX    = '0;
  localparam logic signed [COEF_W-1:0] RST_SIDE   = COEF_W'(16384);
  localparam logic [ONSET_W-1:0]       RST_STEP   = ONSET_W'(ONSET_ONE);

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic signed [SAMPLE_W-1:0] acc_left;
    logic signed [SAMPLE_W-1:0] acc_right;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_word_t;

endpackage

// ----- rtl/stereo_allpass_width_mixer.sv -----
// Each accepted sample word passes the onset ramp (while ramping), the all-pass and mix
// (unless bypassed) and the width stage in turn; a restart word clears filter state.
// New words are stalled until the result is loaded, as every step shares the single 25x18
// multiply-accumulate unit that issues one product per cycle in the sequencer's multiply states.
// Reset (rst_n low, synchronous): registers load their defaults, filter state clears,
// onset gain is full and not ramping, output word is invalid.
module stereo_allpass_width_mixer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sawm_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sawm_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [sawm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sawm_pkg::CFG_W-1:0]       cfg_data
);

  localparam int S     = sawm_pkg::SAMPLE_W;
  localparam int C     = sawm_pkg::COEF_W;
  localparam int CF    = sawm_pkg::CFRAC;
  localparam int OW    = sawm_pkg::ONSET_W;
  localparam int OF    = sawm_pkg::ONSET_FRAC;
  localparam int MA_W  = sawm_pkg::MA_W;
  localparam int MB_W  = sawm_pkg::MB_W;
  localparam int ACC_W = sawm_pkg::ACC_W;

  localparam logic signed [ACC_W-1:0] SMP_MAX = ACC_W'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMP_MIN = -SMP_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RND_C   = ACC_W'(1) <<< (CF - 1);
  localparam logic signed [ACC_W-1:0] RND_O   = ACC_W'(1) <<< (OF - 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ONL   = 5'd1;
  localparam logic [4:0] ST_ONL_W = 5'd2;
  localparam logic [4:0] ST_ONR_W = 5'd3;
  localparam logic [4:0] ST_APL   = 5'd4;
  localparam logic [4:0] ST_APR   = 5'd5;
  localparam logic [4:0] ST_APR_W = 5'd6;
  localparam logic [4:0] ST_MXL1  = 5'd7;
  localparam logic [4:0] ST_MXL2  = 5'd8;
  localparam logic [4:0] ST_MXR1  = 5'd9;
  localparam logic [4:0] ST_MXR2  = 5'd10;
  localparam logic [4:0] ST_MX_W  = 5'd11;
  localparam logic [4:0] ST_WL1   = 5'd12;
  localparam logic [4:0] ST_WL2   = 5'd13;
  localparam logic [4:0] ST_WR1   = 5'd14;
  localparam logic [4:0] ST_WR2   = 5'd15;
  localparam logic [4:0] ST_OUT_W = 5'd16;

  function automatic logic signed [S-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v;
    if (v > SMP_MAX) t = SMP_MAX;
    if (v < SMP_MIN) t = SMP_MIN;
    return t[S-1:0];
  endfunction

  logic [4:0]                 state_r, state_nxt;
  logic signed [C-1:0]        gain_l_r, gain_r_r, side_r;
  logic [C-2:0]               mix_r;
  logic [OW-1:0]              step_r, onset_gain_r;
  logic                       onset_active_r;
  logic signed [S-1:0]        prev_in_l_r, prev_out_l_r, prev_in_r_r, prev_out_r_r;
  logic signed [S-1:0]        l_r, r_r, accl_r, accr_r, ol_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic                       out_valid_r;
  sawm_pkg::out_word_t        out_data_r;

  logic                       mix_on, out_free, mac_en, mac_sub;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b, one_minus_s, w_own, w_oth;
  logic signed [MA_W+MB_W-1:0] prod_raw;
  logic signed [ACC_W-1:0]    prod, base, acc_shr;
  logic [OW:0]                gain_sum;

  assign mix_on      = (32'(mix_r) > sawm_pkg::MIX_THRESH);
  assign out_free    = !out_valid_r || !out_stall;
  assign one_minus_s = MB_W'(1 << CF) - MB_W'(mix_r);
  assign w_own       = MB_W'(1 << (C - 2)) + MB_W'(side_r);
  assign w_oth       = MB_W'(1 << (C - 2)) - MB_W'(side_r);
  assign prod_raw    = mul_a * mul_b;
  assign prod        = ACC_W'(prod_raw);
  assign acc_nxt     = mac_sub ? (base - prod) : (base + prod);
  assign acc_shr     = acc_r >>> CF;
  assign gain_sum    = {1'b0, onset_gain_r} + {1'b0, step_r};

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // multiply-accumulate operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    base    = '0;
    mac_sub = 1'b0;
    mac_en  = 1'b1;
    unique case (state_r)
      ST_ONL: begin
        mul_a = MA_W'(l_r);
        mul_b = MB_W'(onset_gain_r);
        base  = RND_O;
      end
      ST_ONL_W: begin
        mul_a = MA_W'(r_r);
        mul_b = MB_W'(onset_gain_r);
        base  = RND_O;
      end
      ST_APL: begin
        mul_a   = MA_W'(l_r) + MA_W'(prev_out_l_r);
        mul_b   = MB_W'(gain_l_r);
        base    = (ACC_W'(prev_in_l_r) <<< CF) + RND_C;
        mac_sub = 1'b1;
      end
      ST_APR: begin
        mul_a   = MA_W'(r_r) + MA_W'(prev_out_r_r);
        mul_b   = MB_W'(gain_r_r);
        base    = (ACC_W'(prev_in_r_r) <<< CF) + RND_C;
        mac_sub = 1'b1;
      end
      ST_MXL1: begin
        mul_a = MA_W'(l_r);
        mul_b = one_minus_s;
        base  = RND_C;
      end
      ST_MXL2: begin
        mul_a = MA_W'(prev_out_l_r);
        mul_b = MB_W'(mix_r);
        base  = acc_r;
      end
      ST_MXR1: begin
        mul_a = MA_W'(r_r);
        mul_b = one_minus_s;
        base  = RND_C;
      end
      ST_MXR2: begin
        mul_a = MA_W'(prev_out_r_r);
        mul_b = MB_W'(mix_r);
        base  = acc_r;
      end
      ST_WL1: begin
        mul_a = MA_W'(l_r);
        mul_b = w_own;
        base  = RND_C;
      end
      ST_WL2: begin
        mul_a = MA_W'(r_r);
        mul_b = w_oth;
        base  = acc_r;
      end
      ST_WR1: begin
        mul_a = MA_W'(r_r);
        mul_b = w_own;
        base  = RND_C;
      end
      ST_WR2: begin
        mul_a = MA_W'(l_r);
        mul_b = w_oth;
        base  = acc_r;
      end
      default: mac_en = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_data.action) begin
          state_nxt = onset_active_r ? ST_ONL : (mix_on ? ST_APL : ST_WL1);
        end
      end
      ST_ONL:   state_nxt = ST_ONL_W;
      ST_ONL_W: state_nxt = ST_ONR_W;
      ST_ONR_W: state_nxt = mix_on ? ST_APL : ST_WL1;
      ST_APL:   state_nxt = ST_APR;
      ST_APR:   state_nxt = ST_APR_W;
      ST_APR_W: state_nxt = ST_MXL1;
      ST_MXL1:  state_nxt = ST_MXL2;
      ST_MXL2:  state_nxt = ST_MXR1;
      ST_MXR1:  state_nxt = ST_MXR2;
      ST_MXR2:  state_nxt = ST_MX_W;
      ST_MX_W:  state_nxt = ST_WL1;
      ST_WL1:   state_nxt = ST_WL2;
      ST_WL2:   state_nxt = ST_WR1;
      ST_WR1:   state_nxt = ST_WR2;
      ST_WR2:   state_nxt = ST_OUT_W;
      ST_OUT_W: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control, filter state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      onset_gain_r   <= OW'(sawm_pkg::ONSET_ONE);
      onset_active_r <= 1'b0;
      prev_in_l_r    <= '0;
      prev_out_l_r   <= '0;
      prev_in_r_r    <= '0;
      prev_out_r_r   <= '0;
      gain_l_r       <= sawm_pkg::RST_GAIN_L;
      gain_r_r       <= sawm_pkg::RST_GAIN_R;
      mix_r          <= sawm_pkg::RST_MIX;
      side_r         <= sawm_pkg::RST_SIDE;
      step_r         <= sawm_pkg::RST_STEP;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT_W && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == ST_IDLE && in_valid && in_data.action) begin
        prev_in_l_r  <= '0;
        prev_out_l_r <= '0;
        prev_in_r_r  <= '0;
        prev_out_r_r <= '0;
        if (32'(step_r) < sawm_pkg::ONSET_ONE) begin
          onset_active_r <= 1'b1;
          onset_gain_r   <= '0;
        end else begin
          onset_active_r <= 1'b0;
          onset_gain_r   <= OW'(sawm_pkg::ONSET_ONE);
        end
      end

      if (state_r == ST_ONR_W) begin
        if (32'(gain_sum) >= sawm_pkg::ONSET_ONE) begin
          onset_gain_r   <= OW'(sawm_pkg::ONSET_ONE);
          onset_active_r <= 1'b0;
        end else begin
          onset_gain_r <= gain_sum[OW-1:0];
        end
      end

      if (state_r == ST_APR) begin
        prev_in_l_r  <= l_r;
        prev_out_l_r <= sat_smp(acc_shr);
      end
      if (state_r == ST_APR_W) begin
        prev_in_r_r  <= r_r;
        prev_out_r_r <= sat_smp(acc_shr);
      end

      if (cfg_we) begin
        unique case (cfg_index)
          sawm_pkg::REG_GAIN_L: gain_l_r <= cfg_data[C-1:0];
          sawm_pkg::REG_GAIN_R: gain_r_r <= cfg_data[C-1:0];
          sawm_pkg::REG_MIX:    mix_r    <= cfg_data[C-2:0];
          sawm_pkg::REG_SIDE:   side_r   <= cfg_data[C-1:0];
          sawm_pkg::REG_STEP:   step_r   <= cfg_data[OW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (mac_en) acc_r <= acc_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      l_r    <= in_data.left_in;
      r_r    <= in_data.right_in;
      accl_r <= in_data.acc_left;
      accr_r <= in_data.acc_right;
    end
    if (state_r == ST_ONL_W) l_r <= acc_r[OF +: S];
    if (state_r == ST_ONR_W) r_r <= acc_r[OF +: S];
    if (state_r == ST_MXR1)  l_r <= sat_smp(acc_shr);
    if (state_r == ST_MX_W)  r_r <= sat_smp(acc_shr);
    if (state_r == ST_WR1)   ol_r <= sat_smp(ACC_W'(accl_r) + acc_shr);
    if (state_r == ST_OUT_W && out_free) begin
      out_data_r.left_out  <= ol_r;
      out_data_r.right_out <= sat_smp(ACC_W'(accr_r) + acc_shr);
    end
  end

`include "stereo_allpass_width_mixer_assert.svh"

  `SAWM_ASSERT_NOW(a_onset_below_one, onset_active_r,
                   32'(onset_gain_r) < sawm_pkg::ONSET_ONE, "onset gain at unity while ramping")
  `SAWM_ASSERT_NOW(a_allpass_only_when_mixing, state_r == ST_APL, mix_on,
                   "all-pass entered while bypassed")
  `SAWM_ASSERT_NEXT(a_restart_clears, in_valid && !in_stall && in_data.action,
                    prev_in_l_r == '0 && prev_out_r_r == '0 && state_r == ST_IDLE,
                    "restart did not clear filter state")
  `SAWM_ASSERT_NEXT(a_result_loaded, state_r == ST_OUT_W && out_free,
                    out_valid_r && state_r == ST_IDLE, "result word not presented")

endmodule

// ----- sim/width_mix_scoreboard.sv -----
`timescale 1ns / 1ps

package tb_sawm_pkg;
  import sawm_pkg::*;

  localparam logic ACT_PROCESS = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);

  localparam longint S_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint S_MIN = -S_MAX - 1;

  class width_mix_scoreboard;
    logic signed [COEF_W-1:0] gain_l;
    logic signed [COEF_W-1:0] gain_r;
    logic [COEF_W-2:0]        mix;
    logic signed [COEF_W-1:0] side;
    logic [ONSET_W-1:0]       step;

    int unsigned ramp_gain;
    bit          ramping;
    longint      x1_l, y1_l, x1_r, y1_r;

    out_word_t expected_mix[$];
    int        errors;

    function new();
      gain_l    = RST_GAIN_L;
      gain_r    = RST_GAIN_R;
      mix       = RST_MIX;
      side      = RST_SIDE;
      step      = RST_STEP;
      ramp_gain = ONSET_ONE;
      ramping   = 1'b0;
      x1_l      = 0;
      y1_l      = 0;
      x1_r      = 0;
      y1_r      = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_GAIN_L: gain_l = val[COEF_W-1:0];
        REG_GAIN_R: gain_r = val[COEF_W-1:0];
        REG_MIX:    mix    = val[COEF_W-2:0];
        REG_SIDE:   side   = val[COEF_W-1:0];
        REG_STEP:   step   = val[ONSET_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v);
      if (v > S_MAX) return S_MAX;
      if (v < S_MIN) return S_MIN;
      return v;
    endfunction

    function longint allpass_out(longint x, longint x1, longint y1,
                                 logic signed [COEF_W-1:0] g);
      return clip(round_shift(x1 * (longint'(1) << CFRAC) - longint'(g) * (x + y1), CFRAC));
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction

    function void note_word(in_word_t w);
      longint    l, r, yl, yr, s, e, wl, wr, ol, orr;
      longint    one;
      out_word_t want;
      one = longint'(1) << CFRAC;
      if (w.action == ACT_RESTART) begin
        x1_l = 0;
        y1_l = 0;
        x1_r = 0;
        y1_r = 0;
        ramping   = (step < ONSET_ONE);
        ramp_gain = ramping ? 0 : ONSET_ONE;
        return;
      end
      l = longint'(w.left_in);
      r = longint'(w.right_in);
      if (ramping) begin
        l = round_shift(l * longint'(ramp_gain), ONSET_FRAC);
        r = round_shift(r * longint'(ramp_gain), ONSET_FRAC);
        ramp_gain += step;
        if (ramp_gain >= ONSET_ONE) begin
          ramp_gain = ONSET_ONE;
          ramping   = 1'b0;
        end
      end
      if (int'(mix) > MIX_THRESH) begin
        s    = longint'(mix);
        yl   = allpass_out(l, x1_l, y1_l, gain_l);
        yr   = allpass_out(r, x1_r, y1_r, gain_r);
        x1_l = l;
        y1_l = yl;
        x1_r = r;
        y1_r = yr;
        l = clip(round_shift(l * (one - s) + yl * s, CFRAC));
        r = clip(round_shift(r * (one - s) + yr * s, CFRAC));
      end
      e   = longint'(side);
      wl  = (longint'(1) << (COEF_W - 2)) + e;
      wr  = (longint'(1) << (COEF_W - 2)) - e;
      ol  = longint'(w.acc_left) + round_shift(l * wl + r * wr, CFRAC);
      orr = longint'(w.acc_right) + round_shift(r * wl + l * wr, CFRAC);
      want.left_out  = SAMPLE_W'(clip(ol));
      want.right_out = SAMPLE_W'(clip(orr));
      expected_mix.push_back(want);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_mix.size() == 0) begin
        flag($sformatf("unexpected word left_out=%0d right_out=%0d",
                       got.left_out, got.right_out));
        return;
      end
      want = expected_mix.pop_front();
      if (got.left_out !== want.left_out)
        flag($sformatf("left_out expected %0d, got %0d", want.left_out, got.left_out));
      if (got.right_out !== want.right_out)
        flag($sformatf("right_out expected %0d, got %0d", want.right_out, got.right_out));
    endfunction
  endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sawm_pkg::*;
  import tb_sawm_pkg::*;

  localparam int TOTAL_WORDS  = 1850;
  localparam int PHASES       = 24;
  localparam int PHASE_WORDS  = 75;
  localparam int QUIET_CYCLES = 24;
  localparam int LIMIT_CYCLES = 400000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int send_idle_pct = 36;
  int recv_idle_pct = 59;
  int words_sent    = 0;
  int cycles        = 0;

  width_mix_scoreboard sb = new();

  stereo_allpass_width_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic in_word_t make_word(logic act, longint l, longint r,
                                         longint al, longint ar);
    in_word_t w;
    w.action    = act;
    w.left_in   = SAMPLE_W'(l);
    w.right_in  = SAMPLE_W'(r);
    w.acc_left  = SAMPLE_W'(al);
    w.acc_right = SAMPLE_W'(ar);
    return w;
  endfunction

  function automatic longint rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return longint'($urandom_range(0, 511)) - 256;
      default: return longint'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg(logic [CFG_IDX_W-1:0] idx);
    int k;
    k = $urandom_range(0, 7);
    case (idx)
      REG_MIX: begin
        case (k)
          0: return CFG_W'($urandom_range(0, MIX_THRESH));
          1: return CFG_W'(MIX_THRESH + 1);
          2: return CFG_W'((1 << CFRAC) - 1);
          default: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
        endcase
      end
      REG_STEP: begin
        case (k)
          0: return CFG_W'(0);
          1: return CFG_W'(ONSET_ONE - 1);
          2: return CFG_W'(ONSET_ONE);
          3: return CFG_W'((1 << CFG_W) - 1);
          4: return CFG_W'(1);
          default: return CFG_W'($urandom_range(1024, 40000));
        endcase
      end
      default: begin
        case (k)
          0: return CFG_W'(1 << (COEF_W - 1));
          1: return CFG_W'((1 << (COEF_W - 1)) - 1);
          2: return CFG_W'(0);
          default: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
        endcase
      end
    endcase
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    words_sent++;
    if (words_sent == TOTAL_WORDS / 3) begin
      send_idle_pct = 59;
      recv_idle_pct = 36;
    end else if (words_sent == 2 * TOTAL_WORDS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_setting(logic [CFG_W-1:0] gl, logic [CFG_W-1:0] gr,
                              logic [CFG_W-1:0] mx, logic [CFG_W-1:0] sd,
                              logic [CFG_W-1:0] st);
    wait_quiet();
    write_reg(REG_GAIN_L, gl);
    write_reg(REG_GAIN_R, gr);
    write_reg(REG_MIX, mx);
    write_reg(REG_SIDE, sd);
    write_reg(REG_STEP, st);
    write_reg(REG_NONE, CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic act;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: bypass, no ramp, unit width
    send_word(make_word(ACT_PROCESS, S_MAX, S_MAX, S_MAX, S_MAX));
    send_word(make_word(ACT_PROCESS, S_MIN, S_MIN, S_MIN, S_MIN));
    send_word(make_word(ACT_PROCESS, S_MAX, S_MIN, 0, 0));
    send_word(make_word(ACT_PROCESS, 0, 0, S_MIN, S_MAX));
    send_word(make_word(ACT_RESTART, 0, 0, 0, 0));
    send_word(make_word(ACT_PROCESS, 12345, -6789, 100, -100));

    // zero onset step: silent after restart
    load_setting(CFG_W'(32767), CFG_W'(-32768), CFG_W'(32767), CFG_W'(32767), CFG_W'(0));
    send_word(make_word(ACT_RESTART, 0, 0, 0, 0));
    send_word(make_word(ACT_PROCESS, S_MAX, S_MAX, 0, 0));
    send_word(make_word(ACT_PROCESS, S_MIN, S_MAX, 0, 0));

    // oversized step, mix just above bypass
    load_setting(CFG_W'(-32768), CFG_W'(32767), CFG_W'(MIX_THRESH + 1), CFG_W'(-32768),
                 CFG_W'((1 << CFG_W) - 1));
    send_word(make_word(ACT_RESTART, 0, 0, 0, 0));
    send_word(make_word(ACT_PROCESS, S_MAX, S_MIN, 0, 0));
    send_word(make_word(ACT_PROCESS, S_MIN, S_MIN, S_MIN, S_MIN));
    send_word(make_word(ACT_PROCESS, S_MAX, S_MAX, 1, -1));

    // mix at bypass threshold, slowest ramp
    load_setting(CFG_W'(0), CFG_W'(0), CFG_W'(MIX_THRESH), CFG_W'(0), CFG_W'(1));
    send_word(make_word(ACT_RESTART, 0, 0, 0, 0));
    send_word(make_word(ACT_PROCESS, S_MAX, S_MIN, 0, 0));
    send_word(make_word(ACT_PROCESS, S_MIN, S_MAX, S_MAX, S_MIN));

    // short ramp, all-pass gain near one
    load_setting(CFG_W'(32767), CFG_W'(-32768), CFG_W'(20000), CFG_W'(16384), CFG_W'(21846));
    send_word(make_word(ACT_RESTART, 0, 0, 0, 0));
    repeat (3) begin
      send_word(make_word(ACT_PROCESS, S_MAX, S_MIN, 0, 0));
      send_word(make_word(ACT_PROCESS, S_MIN, S_MAX, 0, 0));
    end
    send_word(make_word(ACT_PROCESS, S_MAX, S_MAX, S_MAX, S_MAX));

    for (int p = 0; p < PHASES; p++) begin
      load_setting(pick_reg(REG_GAIN_L), pick_reg(REG_GAIN_R), pick_reg(REG_MIX),
                   pick_reg(REG_SIDE), pick_reg(REG_STEP));
      if ($urandom_range(0, 4) != 0)
        send_word(make_word(ACT_RESTART, rand_sample(), rand_sample(),
                            rand_sample(), rand_sample()));
      repeat (PHASE_WORDS) begin
        act = ($urandom_range(0, 29) == 0) ? ACT_RESTART : ACT_PROCESS;
        send_word(make_word(act, rand_sample(), rand_sample(), rand_sample(), rand_sample()));
      end
    end

    wait_quiet();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
